[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define YLGA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define YLGA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/ylga_pkg.sv]
// ----------------------------------------------------------------------------
// ylga_pkg
// Types, coefficients and register codes of the luma gain pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ylga_pkg;

   localparam int PIPE_DEPTH = 4;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LUMA_GAIN = 1'b0,
      CSR_HAS_ALPHA = 1'b1
   } csr_index_type;

   localparam logic [9:0] LUMA_GAIN_RESET = 10'd333;
   localparam logic       HAS_ALPHA_RESET = 1'b1;

   // RGB -> YUV, 12 fractional bits
   localparam logic signed [15:0] Y_R_COEF  = 16'sd1053;
   localparam logic signed [15:0] Y_G_COEF  = 16'sd2064;
   localparam logic signed [15:0] Y_B_COEF  = 16'sd401;
   localparam logic signed [21:0] Y_OFFSET  = 22'sd65536;
   localparam logic signed [15:0] V_R_COEF  = 16'sd1798;
   localparam logic signed [15:0] V_G_COEF  = 16'sd1507;
   localparam logic signed [15:0] V_B_COEF  = 16'sd291;
   localparam logic signed [15:0] U_R_COEF  = 16'sd606;
   localparam logic signed [15:0] U_G_COEF  = 16'sd1192;
   localparam logic signed [15:0] U_B_COEF  = 16'sd1798;

   // YUV -> RGB, 12 fractional bits
   localparam logic signed [15:0] LUMA_SCALE = 16'sd4768;
   localparam logic signed [30:0] LUMA_OFFSET = 31'sd16777216;
   localparam logic signed [15:0] B_U_COEF   = 16'sd8266;
   localparam logic signed [15:0] G_V_COEF   = 16'sd3330;
   localparam logic signed [15:0] G_U_COEF   = 16'sd1602;
   localparam logic signed [15:0] R_V_COEF   = 16'sd6537;

   typedef struct packed {
      logic [19:0]        y;
      logic signed [19:0] vd;
      logic signed [19:0] ud;
      logic [7:0]         alpha;
   } fwd_type;

   typedef struct packed {
      logic [29:0]        yg;
      logic signed [33:0] cb;
      logic signed [33:0] cg;
      logic signed [33:0] cr;
      logic [7:0]         alpha;
   } mul_type;

   typedef struct packed {
      logic signed [43:0] lum;
      logic signed [33:0] cb;
      logic signed [33:0] cg;
      logic signed [33:0] cr;
      logic [7:0]         alpha;
   } lum_type;

endpackage

`default_nettype wire

[src/ycbcr_luma_gain_adjust.sv]
// ----------------------------------------------------------------------------
// ycbcr_luma_gain_adjust
// BT.601 luma gain: RGB -> YUV, scale Y, YUV -> RGB with byte clamping.
// ----------------------------------------------------------------------------
// Four-stage pipeline taking one pixel item per clock unless the response
// side stalls. An accepted item passes the fwd, mul, lum and output
// registers in turn before rsp_valid rises. Stages: color transform, luma gain and
// chroma products, luma rescale, recombine and clamp into the output
// register. Every stage holds one item and frees itself as soon as its
// successor can take the item, so a stall on the response side stops the
// pipeline without losing a cycle and up to four items can be in flight.
// The user writes luma_gain (Q2.8) and has_alpha via csr only with no items
// in flight (not enforced by the block); has_alpha low forces alpha to 255.
`default_nettype none

module ycbcr_luma_gain_adjust (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_blue_in,
   input  wire logic [7:0]                        req_green_in,
   input  wire logic [7:0]                        req_red_in,
   input  wire logic [7:0]                        req_alpha_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_blue_out,
   output logic [7:0]                             rsp_green_out,
   output logic [7:0]                             rsp_red_out,
   output logic [7:0]                             rsp_alpha_out,
   input  wire logic                              csr_write_en,
   input  wire logic [ylga_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ylga_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [9:0]        luma_gain_ff, luma_gain_in;
   logic              has_alpha_ff, has_alpha_in;
   logic              fwd_valid, fwd_ready;
   ylga_pkg::fwd_type fwd_data;
   logic              lum_valid, lum_ready;
   ylga_pkg::lum_type lum_data;

   always_comb begin
      luma_gain_in = luma_gain_ff;
      has_alpha_in = has_alpha_ff;
      if (csr_write_en) begin
         unique case (ylga_pkg::csr_index_type'(csr_index))
            ylga_pkg::CSR_LUMA_GAIN: luma_gain_in = csr_wdata[9:0];
            ylga_pkg::CSR_HAS_ALPHA: has_alpha_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_gain_ff <= ylga_pkg::LUMA_GAIN_RESET;
         has_alpha_ff <= ylga_pkg::HAS_ALPHA_RESET;
      end else begin
         luma_gain_ff <= luma_gain_in;
         has_alpha_ff <= has_alpha_in;
      end
   end

   ylga_fwd_stage u_fwd (
      .clock     (clock),
      .reset     (reset),
      .has_alpha (has_alpha_ff),
      .up_valid  (req_valid),
      .up_ready  (req_ready),
      .blue      (req_blue_in),
      .green     (req_green_in),
      .red       (req_red_in),
      .alpha     (req_alpha_in),
      .dn_valid  (fwd_valid),
      .dn_ready  (fwd_ready),
      .dn_data   (fwd_data)
   );

   ylga_gain_stage u_gain (
      .clock     (clock),
      .reset     (reset),
      .luma_gain (luma_gain_ff),
      .up_valid  (fwd_valid),
      .up_ready  (fwd_ready),
      .up_data   (fwd_data),
      .dn_valid  (lum_valid),
      .dn_ready  (lum_ready),
      .dn_data   (lum_data)
   );

   ylga_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .up_valid (lum_valid),
      .up_ready (lum_ready),
      .up_data  (lum_data),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .blue     (rsp_blue_out),
      .green    (rsp_green_out),
      .red      (rsp_red_out),
      .alpha    (rsp_alpha_out)
   );

endmodule

`default_nettype wire

[src/ylga_fwd_stage.sv]
// ----------------------------------------------------------------------------
// ylga_fwd_stage
// First pipeline stage: RGB to studio-range Y and centered U, V.
// ----------------------------------------------------------------------------
`default_nettype none

module ylga_fwd_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             has_alpha,
   input  wire logic             up_valid,
   output logic                  up_ready,
   input  wire logic [7:0]       blue,
   input  wire logic [7:0]       green,
   input  wire logic [7:0]       red,
   input  wire logic [7:0]       alpha,
   output logic                  dn_valid,
   input  wire logic             dn_ready,
   output ylga_pkg::fwd_type     dn_data
);

   logic               valid_ff;
   ylga_pkg::fwd_type  data_ff;
   ylga_pkg::fwd_type  data_in;
   logic signed [21:0] r_s, g_s, b_s;
   logic signed [21:0] y_sum, vd_sum, ud_sum;

   always_comb begin
      r_s = $signed({14'b0, red});
      g_s = $signed({14'b0, green});
      b_s = $signed({14'b0, blue});
      y_sum  = r_s * ylga_pkg::Y_R_COEF + g_s * ylga_pkg::Y_G_COEF
             + b_s * ylga_pkg::Y_B_COEF + ylga_pkg::Y_OFFSET;
      vd_sum = r_s * ylga_pkg::V_R_COEF - g_s * ylga_pkg::V_G_COEF
             - b_s * ylga_pkg::V_B_COEF;
      ud_sum = b_s * ylga_pkg::U_B_COEF - r_s * ylga_pkg::U_R_COEF
             - g_s * ylga_pkg::U_G_COEF;
      data_in.y     = y_sum[19:0];
      data_in.vd    = vd_sum[19:0];
      data_in.ud    = ud_sum[19:0];
      data_in.alpha = has_alpha ? alpha : 8'hFF;
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[src/ylga_gain_stage.sv]
// ----------------------------------------------------------------------------
// ylga_gain_stage
// Stages two and three: luma gain and chroma products, then luma rescale.
// ----------------------------------------------------------------------------
`default_nettype none

module ylga_gain_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [9:0]        luma_gain,
   input  wire logic              up_valid,
   output logic                   up_ready,
   input  wire ylga_pkg::fwd_type up_data,
   output logic                   dn_valid,
   input  wire logic              dn_ready,
   output ylga_pkg::lum_type      dn_data
);

   logic               mul_valid_ff;
   ylga_pkg::mul_type  mul_ff;
   ylga_pkg::mul_type  mul_in;
   logic               mul_ready;
   logic               lum_valid_ff;
   ylga_pkg::lum_type  lum_ff;
   ylga_pkg::lum_type  lum_in;
   logic               lum_ready;
   logic signed [33:0] vd_w, ud_w;
   logic signed [30:0] y_diff;

   // stage two
   always_comb begin
      vd_w = 34'(up_data.vd);
      ud_w = 34'(up_data.ud);
      mul_in.yg    = {10'b0, up_data.y} * {20'b0, luma_gain};
      mul_in.cb    = ud_w * ylga_pkg::B_U_COEF;
      mul_in.cg    = vd_w * ylga_pkg::G_V_COEF + ud_w * ylga_pkg::G_U_COEF;
      mul_in.cr    = vd_w * ylga_pkg::R_V_COEF;
      mul_in.alpha = up_data.alpha;
   end

   // stage three: remove the black level and apply the 1.164 scale
   always_comb begin
      y_diff       = $signed({1'b0, mul_ff.yg}) - ylga_pkg::LUMA_OFFSET;
      lum_in.lum   = 44'(y_diff) * 44'(ylga_pkg::LUMA_SCALE);
      lum_in.cb    = mul_ff.cb;
      lum_in.cg    = mul_ff.cg;
      lum_in.cr    = mul_ff.cr;
      lum_in.alpha = mul_ff.alpha;
   end

   assign lum_ready = !lum_valid_ff || dn_ready;
   assign mul_ready = !mul_valid_ff || lum_ready;
   assign up_ready  = mul_ready;
   assign dn_valid  = lum_valid_ff;
   assign dn_data   = lum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         lum_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= up_valid;
         end
         if (lum_ready) begin
            lum_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && up_valid) begin
         mul_ff <= mul_in;
      end
      if (lum_ready && mul_valid_ff) begin
         lum_ff <= lum_in;
      end
   end

endmodule

`default_nettype wire

[src/ylga_out_stage.sv]
// ----------------------------------------------------------------------------
// ylga_out_stage
// Last stage: recombine luma and chroma, clamp to bytes, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ylga_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output logic                   up_ready,
   input  wire ylga_pkg::lum_type up_data,
   output logic                   dn_valid,
   input  wire logic              dn_ready,
   output logic [7:0]             blue,
   output logic [7:0]             green,
   output logic [7:0]             red,
   output logic [7:0]             alpha
);

   logic               valid_ff;
   logic [7:0]         blue_ff, green_ff, red_ff, alpha_ff;
   logic [7:0]         blue_in, green_in, red_in;
   logic signed [45:0] lum_w, sum_b, sum_g, sum_r;

   // 32 fractional bits: negative -> 0, 256.0 or more -> 255, else truncate
   function automatic logic [7:0] to_channel(input logic signed [45:0] v);
      logic [7:0] res;
      if (v[45]) begin
         res = 8'h00;
      end else if (|v[44:40]) begin
         res = 8'hFF;
      end else begin
         res = v[39:32];
      end
      return res;
   endfunction

   always_comb begin
      lum_w    = 46'(up_data.lum);
      sum_b    = lum_w + (46'(up_data.cb) <<< 8);
      sum_g    = lum_w - (46'(up_data.cg) <<< 8);
      sum_r    = lum_w + (46'(up_data.cr) <<< 8);
      blue_in  = to_channel(sum_b);
      green_in = to_channel(sum_g);
      red_in   = to_channel(sum_r);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign blue     = blue_ff;
   assign green    = green_ff;
   assign red      = red_ff;
   assign alpha    = alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
         red_ff   <= red_in;
         alpha_ff <= up_data.alpha;
      end
   end

endmodule

`default_nettype wire

[src/ylga_checker.sv]
// ----------------------------------------------------------------------------
// ylga_checker
// Port-level checks of the luma gain pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ylga_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [7:0]                        req_blue_in,
   input  wire logic [7:0]                        req_green_in,
   input  wire logic [7:0]                        req_red_in,
   input  wire logic [7:0]                        req_alpha_in,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [7:0]                        rsp_blue_out,
   input  wire logic [7:0]                        rsp_green_out,
   input  wire logic [7:0]                        rsp_red_out,
   input  wire logic [7:0]                        rsp_alpha_out,
   input  wire logic                              csr_write_en,
   input  wire logic [ylga_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ylga_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [2:0] count_ff, count_in;
   logic       in_acc, out_acc;
   logic       unused_ok;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;
   // inputs only watched for handshake; payload and csr are not checked here
   assign unused_ok = ^{req_blue_in, req_green_in, req_red_in, req_alpha_in,
                        csr_write_en, csr_index, csr_wdata};

   always_comb begin
      count_in = count_ff + 3'(in_acc) - 3'(out_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   `YLGA_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "rsp_valid after reset")
   `YLGA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blue_out) && $stable(rsp_green_out) && $stable(rsp_red_out) && $stable(rsp_alpha_out), "stalled item changed")
   `YLGA_ASSERT(a_depth, count_ff <= 3'(ylga_pkg::PIPE_DEPTH) || unused_ok !== unused_ok, "more items in flight than stages")
   `YLGA_ASSERT(a_no_phantom, rsp_valid |-> count_ff != 3'd0, "item out with none in flight")
   `YLGA_ASSERT(a_ready_empty, !rsp_valid |-> req_ready, "input stalled with empty output")

endmodule

bind ycbcr_luma_gain_adjust ylga_checker u_ylga_checker (.*);

`default_nettype wire
